// File: hw/rtl/jcc_pkg.sv
package jcc_pkg;

    // Sample and accumulator widths
    localparam int ADC_BITS  = 12;
    localparam int SUM_W     = 28;
    localparam int CNT_W     = 16;
    localparam int ZONE_W    = 13;
    localparam int CMP_W     = ZONE_W + 2;

    localparam logic [CNT_W-1:0]    MAX_SAMPLES  = CNT_W'(65535);
    localparam logic [ADC_BITS-1:0] ADC_MAX      = {ADC_BITS{1'b1}};
    localparam logic [ADC_BITS-1:0] CENTER_RESET = ADC_BITS'(2048);
    localparam logic [ZONE_W-1:0]   ZONE_RESET   = ZONE_W'(400);

    // Dead zone scaling: x uses 9/10, y uses 21/20 = (21/4)/5
    localparam int              ZMX_W      = 16;
    localparam int              ZMY_W      = 15;
    localparam logic [3:0]      ZX_NUM     = 4'd9;
    localparam logic [4:0]      ZY_NUM     = 5'd21;
    localparam logic [15:0]     RECIP_MUL  = 16'hCCCD;
    localparam int              DIV10_SHR  = 19;
    localparam int              DIV5_SHR   = 18;

    // Restoring divider, one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int ITER_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_START    = 2'd1,
        OP_SAMPLE   = 2'd2,
        OP_FINISH   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [ADC_BITS-1:0] x;
        logic [ADC_BITS-1:0] y;
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DIV  = 1'b1
    } t_state;

endpackage

// File: hw/rtl/joystick_calibrate_and_classify_unit.sv
// Channel  Handshake                Payload
// input    i_in_valid / o_in_stall  i_action, i_x_sample, i_y_sample
// output   o_out_valid / i_out_stall o_is_*, o_cal_ok, o_center_*_out, o_zone_*_out
//
// Classify, start and sample words execute when popped from the queue; the output
// word passes through the input register, the queue and the output register.
// A finish with samples holds execute while the divider runs: one restoring divide
// step per cycle on the 28-bit sums, both axes in parallel.
// Reset is synchronous, active low; it restores the power-up calibration.
// Input and output sides stall independently through the two-word queue.
module joystick_calibrate_and_classify_unit
    import jcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_action,
    input  logic [ADC_BITS-1:0] i_x_sample,
    input  logic [ADC_BITS-1:0] i_y_sample,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_is_up,
    output logic                o_is_down,
    output logic                o_is_right,
    output logic                o_is_left,
    output logic                o_is_centered,
    output logic                o_cal_ok,
    output logic [ADC_BITS-1:0] o_center_x_out,
    output logic [ADC_BITS-1:0] o_center_y_out,
    output logic [ZONE_W-1:0]   o_zone_x_out,
    output logic [ZONE_W-1:0]   o_zone_y_out
);

    logic push;
    t_cmd push_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    jcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_action   (i_action),
        .i_x_sample (i_x_sample),
        .i_y_sample (i_y_sample),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_q_ready  (q_ready)
    );

    jcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    jcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_up        (o_is_up),
        .o_is_down      (o_is_down),
        .o_is_right     (o_is_right),
        .o_is_left      (o_is_left),
        .o_is_centered  (o_is_centered),
        .o_cal_ok       (o_cal_ok),
        .o_center_x_out (o_center_x_out),
        .o_center_y_out (o_center_y_out),
        .o_zone_x_out   (o_zone_x_out),
        .o_zone_y_out   (o_zone_y_out)
    );

endmodule

// File: hw/rtl/jcc_front.sv
module jcc_front
    import jcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_action,
    input  logic [ADC_BITS-1:0] i_x_sample,
    input  logic [ADC_BITS-1:0] i_y_sample,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_q_ready
);

    logic r_vld;
    logic n_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // Hold the word while the queue is full
    assign o_in_stall = r_vld && !i_q_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_vld && i_q_ready;
    assign o_cmd      = r_cmd;

    // Decode the action code into a command
    always_comb begin
        n_cmd.x = i_x_sample;
        n_cmd.y = i_y_sample;
        case (i_action)
            OP_CLASSIFY: n_cmd.op = OP_CLASSIFY;
            OP_START:    n_cmd.op = OP_START;
            OP_SAMPLE:   n_cmd.op = OP_SAMPLE;
            OP_FINISH:   n_cmd.op = OP_FINISH;
            default:     n_cmd.op = OP_CLASSIFY;
        endcase
    end

    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: hw/rtl/jcc_queue.sv
module jcc_queue
    import jcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    // Two-entry shifting queue; head always sits in entry 0
    t_cmd       r_ent [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       wr_idx;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[0];

    assign wr_idx = (r_cnt == 2'd2) || ((r_cnt == 2'd1) && !i_pop);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Shift on pop; a push lands behind whatever stays
    always_ff @(posedge i_clk) begin
        if (i_push && !wr_idx) begin
            r_ent[0] <= i_cmd;
        end else if (i_pop) begin
            r_ent[0] <= r_ent[1];
        end
        if (i_push && wr_idx) begin
            r_ent[1] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/jcc_back.sv
module jcc_back
    import jcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_is_up,
    output logic                o_is_down,
    output logic                o_is_right,
    output logic                o_is_left,
    output logic                o_is_centered,
    output logic                o_cal_ok,
    output logic [ADC_BITS-1:0] o_center_x_out,
    output logic [ADC_BITS-1:0] o_center_y_out,
    output logic [ZONE_W-1:0]   o_zone_x_out,
    output logic [ZONE_W-1:0]   o_zone_y_out
);

    t_state r_state;
    t_state n_state;

    // Calibration state
    logic [ADC_BITS-1:0] r_center_x;
    logic [ADC_BITS-1:0] r_center_y;
    logic [ZONE_W-1:0]   r_zone_x;
    logic [ZONE_W-1:0]   r_zone_y;
    logic [ADC_BITS-1:0] r_min_x;
    logic [ADC_BITS-1:0] r_max_x;
    logic [ADC_BITS-1:0] r_min_y;
    logic [ADC_BITS-1:0] r_max_y;
    logic [SUM_W-1:0]    r_sum_x;
    logic [SUM_W-1:0]    r_sum_y;
    logic [CNT_W-1:0]    r_count;

    // Divider and zone scaling
    logic [SUM_W-1:0]    r_ax;
    logic [SUM_W-1:0]    r_ay;
    logic [CNT_W-1:0]    r_rx;
    logic [CNT_W-1:0]    r_ry;
    logic [ITER_W-1:0]   r_iter;
    logic [ZMX_W-1:0]    r_zx_m;
    logic [ZMY_W-1:0]    r_zy_m;
    logic [ZONE_W-1:0]   r_zx_q;
    logic [ZONE_W-1:0]   r_zy_q;

    // Output register
    logic                r_out_valid;
    logic                r_up;
    logic                r_down;
    logic                r_right;
    logic                r_left;
    logic                r_centered;
    logic                r_ok;
    logic [ADC_BITS-1:0] r_ocx;
    logic [ADC_BITS-1:0] r_ocy;
    logic [ZONE_W-1:0]   r_ozx;
    logic [ZONE_W-1:0]   r_ozy;

    logic                out_free;
    logic                div_done;
    logic                cnt_zero;
    logic                go_div;
    logic                load;
    logic                is_cls;

    logic signed [CMP_W-1:0] sx;
    logic signed [CMP_W-1:0] sy;
    logic signed [CMP_W-1:0] cx;
    logic signed [CMP_W-1:0] cy;
    logic signed [CMP_W-1:0] zx;
    logic signed [CMP_W-1:0] zy;
    logic                    c_up;
    logic                    c_down;
    logic                    c_right;
    logic                    c_left;

    logic [ADC_BITS-1:0] span_x;
    logic [ADC_BITS-1:0] span_y;
    logic [ZMY_W+1:0]    prod_y;
    logic [31:0]         px;
    logic [31:0]         py;

    logic [CNT_W:0]      trial_x;
    logic [CNT_W:0]      trial_y;
    logic                ge_x;
    logic                ge_y;
    logic [CNT_W-1:0]    n_rx;
    logic [CNT_W-1:0]    n_ry;
    logic [SUM_W-1:0]    n_ax;
    logic [SUM_W-1:0]    n_ay;

    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_zero = (r_count == '0);
    assign is_cls   = (i_cmd.op == OP_CLASSIFY);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop && (i_cmd.op == OP_FINISH) && !cnt_zero) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop    = 1'b0;
        div_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = i_cmd_valid && out_free;
            end
            S_DIV: begin
                div_done = (r_iter == ITER_W'(DIV_STEPS - 1));
            end
            default: begin
                o_pop    = 1'b0;
                div_done = 1'b0;
            end
        endcase
    end

    assign go_div = o_pop && (i_cmd.op == OP_FINISH) && !cnt_zero;
    assign load   = (o_pop && !go_div) || div_done;

    // Direction compare in signed arithmetic
    assign sx = CMP_W'(i_cmd.x);
    assign sy = CMP_W'(i_cmd.y);
    assign cx = CMP_W'(r_center_x);
    assign cy = CMP_W'(r_center_y);
    assign zx = CMP_W'(r_zone_x);
    assign zy = CMP_W'(r_zone_y);

    assign c_up    = sy < (cy - zy);
    assign c_down  = sy > (cy + zy);
    assign c_right = sx > (cx + zx);
    assign c_left  = sx < (cx - zx);

    // Spans and dead zone products
    assign span_x = (r_max_x > r_min_x) ? (r_max_x - r_min_x) : '0;
    assign span_y = (r_max_y > r_min_y) ? (r_max_y - r_min_y) : '0;
    assign prod_y = (ZMY_W + 2)'(span_y) * (ZMY_W + 2)'(ZY_NUM);
    assign px     = 32'(r_zx_m) * 32'(RECIP_MUL);
    assign py     = 32'(r_zy_m) * 32'(RECIP_MUL);

    // One restoring step per axis
    assign trial_x = {r_rx, r_ax[SUM_W-1]};
    assign trial_y = {r_ry, r_ay[SUM_W-1]};
    assign ge_x    = trial_x >= {1'b0, r_count};
    assign ge_y    = trial_y >= {1'b0, r_count};
    assign n_rx    = ge_x ? CNT_W'(trial_x - {1'b0, r_count}) : trial_x[CNT_W-1:0];
    assign n_ry    = ge_y ? CNT_W'(trial_y - {1'b0, r_count}) : trial_y[CNT_W-1:0];
    assign n_ax    = {r_ax[SUM_W-2:0], ge_x};
    assign n_ay    = {r_ay[SUM_W-2:0], ge_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_center_x <= CENTER_RESET;
            r_center_y <= CENTER_RESET;
            r_zone_x   <= ZONE_RESET;
            r_zone_y   <= ZONE_RESET;
            r_min_x    <= ADC_MAX;
            r_min_y    <= ADC_MAX;
            r_max_x    <= '0;
            r_max_y    <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_count    <= '0;
            r_iter     <= '0;
        end else begin
            r_state <= n_state;
            // accumulator updates
            if (o_pop && (i_cmd.op == OP_START)) begin
                r_min_x <= ADC_MAX;
                r_min_y <= ADC_MAX;
                r_max_x <= '0;
                r_max_y <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else if (o_pop && (i_cmd.op == OP_SAMPLE) && (r_count != MAX_SAMPLES)) begin
                r_sum_x <= r_sum_x + SUM_W'(i_cmd.x);
                r_sum_y <= r_sum_y + SUM_W'(i_cmd.y);
                if (i_cmd.x < r_min_x) begin
                    r_min_x <= i_cmd.x;
                end
                if (i_cmd.x > r_max_x) begin
                    r_max_x <= i_cmd.x;
                end
                if (i_cmd.y < r_min_y) begin
                    r_min_y <= i_cmd.y;
                end
                if (i_cmd.y > r_max_y) begin
                    r_max_y <= i_cmd.y;
                end
                r_count <= r_count + CNT_W'(1);
            end
            // divider step counter
            if (go_div) begin
                r_iter <= '0;
            end else if (r_state == S_DIV) begin
                r_iter <= r_iter + ITER_W'(1);
            end
            // commit new calibration
            if (div_done) begin
                r_center_x <= n_ax[ADC_BITS-1:0];
                r_center_y <= n_ay[ADC_BITS-1:0];
                r_zone_x   <= r_zx_q;
                r_zone_y   <= r_zy_q;
            end
        end
    end

    // Divider datapath and zone scaling
    always_ff @(posedge i_clk) begin
        if (go_div) begin
            r_ax   <= r_sum_x;
            r_ay   <= r_sum_y;
            r_rx   <= '0;
            r_ry   <= '0;
            r_zx_m <= ZMX_W'(span_x) * ZMX_W'(ZX_NUM);
            r_zy_m <= prod_y[ZMY_W+1:2];
        end else if (r_state == S_DIV) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_zx_q <= px[DIV10_SHR +: ZONE_W];
            r_zy_q <= py[DIV5_SHR +: ZONE_W];
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_up       <= 1'b0;
            r_down     <= 1'b0;
            r_right    <= 1'b0;
            r_left     <= 1'b0;
            r_centered <= 1'b0;
            r_ok       <= 1'b1;
            r_ocx      <= n_ax[ADC_BITS-1:0];
            r_ocy      <= n_ay[ADC_BITS-1:0];
            r_ozx      <= r_zx_q;
            r_ozy      <= r_zy_q;
        end else if (load) begin
            r_up       <= is_cls && c_up;
            r_down     <= is_cls && c_down;
            r_right    <= is_cls && c_right;
            r_left     <= is_cls && c_left;
            r_centered <= is_cls && !c_up && !c_down && !c_right && !c_left;
            r_ok       <= 1'b0;
            r_ocx      <= r_center_x;
            r_ocy      <= r_center_y;
            r_ozx      <= r_zone_x;
            r_ozy      <= r_zone_y;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_up        = r_up;
    assign o_is_down      = r_down;
    assign o_is_right     = r_right;
    assign o_is_left      = r_left;
    assign o_is_centered  = r_centered;
    assign o_cal_ok       = r_ok;
    assign o_center_x_out = r_ocx;
    assign o_center_y_out = r_ocy;
    assign o_zone_x_out   = r_ozx;
    assign o_zone_y_out   = r_ozy;

`ifndef SYNTHESIS
    // divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != '0))
        else $error("divide started with empty sample count");

    // output slot stays empty while a finish is in progress
    a_div_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_out_valid)
        else $error("output word pending during divide");

    // taken samples keep min and max ordered
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> ((r_min_x <= r_max_x) && (r_min_y <= r_max_y)))
        else $error("min above max with samples taken");

    // a divide finishing always produces a word next cycle
    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |=> (r_out_valid && r_ok))
        else $error("finish result not presented");
`endif

endmodule
